### src/pic_pkg.sv
// Shared types, command codes and control-word constants for the interrupt controller.
`default_nettype none

package pic_pkg;

    // Beat command codes
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_ACK    = 2'd3
    } pic_cmd_t;

    // Port select codes
    localparam logic PORT_CMD  = 1'b0;
    localparam logic PORT_DATA = 1'b1;

    // Control-word bits
    localparam logic [7:0] ICW1_INIT      = 8'h10;
    localparam logic [7:0] ICW1_NEED_ICW4 = 8'h01;
    localparam logic [7:0] ICW1_SINGLE    = 8'h02;
    localparam logic [7:0] ICW1_LEVEL     = 8'h08;
    localparam logic [7:0] ICW4_AUTO_EOI  = 8'h02;
    localparam logic [7:0] OCW3_FLAG      = 8'h08;
    localparam logic [7:0] OCW3_READ_IRR  = 8'h0a;
    localparam logic [7:0] OCW3_READ_ISR  = 8'h0b;
    localparam logic [7:0] OCW2_NS_EOI    = 8'h20;
    localparam logic [7:0] OCW2_CODE_MASK = 8'he0;

    // One accepted input beat
    typedef struct packed {
        pic_cmd_t   cmd;
        logic       port_select;
        logic [7:0] write_data;
        logic [7:0] irq_lines;
    } pic_item_t;

    // One result beat
    typedef struct packed {
        logic [7:0] read_data;
        logic       int_out;
        logic [7:0] vector;
        logic       vector_valid;
    } pic_result_t;

    // Lowest set bit index; bit 3 set means no bit set
    function automatic logic [3:0] first_bit(input logic [7:0] v);
        logic [3:0] idx;
        idx = 4'd8;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### src/pic_if.sv
// Valid/ready channel interfaces for controller input beats and result beats.
`default_nettype none

interface pic_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       port_select;
    logic [7:0] write_data;
    logic [7:0] irq_lines;

    modport source (output valid, output cmd, output port_select, output write_data,
                    output irq_lines, input ready);
    modport sink   (input valid, input cmd, input port_select, input write_data,
                    input irq_lines, output ready);
endinterface

interface pic_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       int_out;
    logic [7:0] vector;
    logic       vector_valid;

    modport source (output valid, output read_data, output int_out, output vector,
                    output vector_valid, input ready);
    modport sink   (input valid, input read_data, input int_out, input vector,
                    input vector_valid, output ready);
endinterface

`default_nettype wire

### src/pic_prio.sv
// Fixed-priority resolver: picks the unmasked request that outranks all in-service levels.
`default_nettype none

module pic_prio
    import pic_pkg::*;
(
    input  logic [7:0] irr,
    input  logic [7:0] imr,
    input  logic [7:0] isr,
    output logic [3:0] win
);

    logic [3:0] req_idx;
    logic [3:0] srv_idx;

    // Line 0 ranks highest; index eight means nothing qualifies
    assign req_idx = first_bit(irr & ~imr);
    assign srv_idx = first_bit(isr);
    assign win     = (req_idx < srv_idx) ? req_idx : 4'd8;

endmodule

`default_nettype wire

### src/pic_core.sv
// Controller state: init sequence, IRR/ISR/IMR and mode bits, updated once per beat.
`default_nettype none

module pic_core
    import pic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  pic_item_t   item,
    output pic_result_t res
);

    typedef enum logic [1:0] {
        INIT_IDLE = 2'd0,
        INIT_ICW2 = 2'd1,
        INIT_ICW3 = 2'd2,
        INIT_ICW4 = 2'd3
    } init_t;

    init_t      init_reg,   init_next;
    logic [7:0] irr_reg,    irr_next;
    logic [7:0] isr_reg,    isr_next;
    logic [7:0] imr_reg,    imr_next;
    logic [4:0] base_reg,   base_next;
    logic       icw4_reg,   icw4_next;
    logic       single_reg, single_next;
    logic       level_reg,  level_next;
    logic       aeoi_reg,   aeoi_next;
    logic       rsel_reg,   rsel_next;
    logic [7:0] prev_reg,   prev_next;

    logic [3:0] win_now;
    logic [3:0] win_after;

    pic_prio u_prio_now (
        .irr (irr_reg),
        .imr (imr_reg),
        .isr (isr_reg),
        .win (win_now)
    );

    pic_prio u_prio_after (
        .irr (irr_next),
        .imr (imr_next),
        .isr (isr_next),
        .win (win_after)
    );

    // Decode the beat and form next state and result
    always_comb
    begin
        init_next   = init_reg;
        irr_next    = irr_reg;
        isr_next    = isr_reg;
        imr_next    = imr_reg;
        base_next   = base_reg;
        icw4_next   = icw4_reg;
        single_next = single_reg;
        level_next  = level_reg;
        aeoi_next   = aeoi_reg;
        rsel_next   = rsel_reg;
        prev_next   = prev_reg;

        res.read_data    = 8'h00;
        res.vector       = 8'h00;
        res.vector_valid = 1'b0;

        case (item.cmd)
            CMD_WRITE:
            begin
                if (item.port_select == PORT_DATA)
                begin
                    case (init_reg)
                        INIT_ICW2:
                        begin
                            base_next = item.write_data[7:3];
                            if (!single_reg)
                            begin
                                init_next = INIT_ICW3;
                            end
                            else
                            begin
                                init_next = icw4_reg ? INIT_ICW4 : INIT_IDLE;
                            end
                        end
                        INIT_ICW3:
                        begin
                            // Cascade wiring word carries nothing this unit acts on
                            init_next = icw4_reg ? INIT_ICW4 : INIT_IDLE;
                        end
                        INIT_ICW4:
                        begin
                            aeoi_next = (item.write_data & ICW4_AUTO_EOI) != 8'h00;
                            init_next = INIT_IDLE;
                        end
                        default:
                        begin
                            imr_next = item.write_data;
                        end
                    endcase
                end
                else if ((item.write_data & ICW1_INIT) != 8'h00)
                begin
                    // ICW1: restart the sequence, keep IRR and ISR
                    imr_next    = 8'h00;
                    rsel_next   = 1'b0;
                    level_next  = (item.write_data & ICW1_LEVEL) != 8'h00;
                    single_next = (item.write_data & ICW1_SINGLE) != 8'h00;
                    icw4_next   = (item.write_data & ICW1_NEED_ICW4) != 8'h00;
                    aeoi_next   = 1'b0;
                    init_next   = INIT_ICW2;
                end
                else if ((item.write_data & OCW3_FLAG) != 8'h00)
                begin
                    // OCW3: read-register select when its enable bit is set
                    if ((item.write_data & (OCW3_READ_IRR & ~OCW3_FLAG)) != 8'h00)
                    begin
                        rsel_next = (item.write_data & (OCW3_READ_ISR & ~OCW3_READ_IRR))
                                    != 8'h00;
                    end
                end
                else if ((item.write_data & OCW2_CODE_MASK) == OCW2_NS_EOI)
                begin
                    // Non-specific EOI: drop the highest-priority in-service bit
                    isr_next = isr_reg & (isr_reg - 8'd1);
                end
            end
            CMD_READ:
            begin
                if (item.port_select == PORT_DATA)
                begin
                    res.read_data = imr_reg;
                end
                else
                begin
                    res.read_data = rsel_reg ? isr_reg : irr_reg;
                end
            end
            CMD_SAMPLE:
            begin
                if (level_reg)
                begin
                    irr_next = item.irq_lines;
                end
                else
                begin
                    irr_next = irr_reg | (item.irq_lines & ~prev_reg);
                end
                prev_next = item.irq_lines;
            end
            CMD_ACK:
            begin
                if (!win_now[3])
                begin
                    irr_next = irr_reg & ~(8'd1 << win_now[2:0]);
                    if (!aeoi_reg)
                    begin
                        isr_next = isr_reg | (8'd1 << win_now[2:0]);
                    end
                    res.vector       = {base_reg, win_now[2:0]};
                    res.vector_valid = 1'b1;
                end
                else
                begin
                    // Spurious acknowledge: lowest-priority vector, no state change
                    res.vector = {base_reg, 3'b111};
                end
            end
            default:
            begin
                res.read_data = 8'h00;
            end
        endcase

        res.int_out = !win_after[3];
    end

    // Hold state; advance only on a processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg   <= INIT_IDLE;
            irr_reg    <= 8'h00;
            isr_reg    <= 8'h00;
            imr_reg    <= 8'h00;
            base_reg   <= 5'd0;
            icw4_reg   <= 1'b0;
            single_reg <= 1'b0;
            level_reg  <= 1'b0;
            aeoi_reg   <= 1'b0;
            rsel_reg   <= 1'b0;
            prev_reg   <= 8'h00;
        end
        else if (fire)
        begin
            init_reg   <= init_next;
            irr_reg    <= irr_next;
            isr_reg    <= isr_next;
            imr_reg    <= imr_next;
            base_reg   <= base_next;
            icw4_reg   <= icw4_next;
            single_reg <= single_next;
            level_reg  <= level_next;
            aeoi_reg   <= aeoi_next;
            rsel_reg   <= rsel_next;
            prev_reg   <= prev_next;
        end
    end

`ifndef SYNTHESIS
    // ISR gains bits only through an acknowledge beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && item.cmd == CMD_ACK) |=> ((isr_reg & ~$past(isr_reg)) == 8'h00))
        else $error("ISR bit set outside an acknowledge");

    // Auto EOI never leaves a line in service
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && aeoi_reg) |=> ((isr_reg & ~$past(isr_reg)) == 8'h00))
        else $error("ISR grew with auto EOI on");

    // A delivered vector moves exactly one line out of IRR
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.vector_valid) |=>
            ($countones($past(irr_reg) & ~irr_reg) == 1))
        else $error("acknowledge did not clear exactly one request");

    // Interrupt output is raised only while an unmasked request is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.int_out) |-> ((irr_next & ~imr_next) != 8'h00))
        else $error("interrupt raised with no unmasked request");
`endif

endmodule

`default_nettype wire

### src/programmable_interrupt_controller.sv
// Top level of the 8259A-style interrupt controller: input register, core, result register.
`default_nettype none

// Every input beat (bus write, bus read, line sample or acknowledge) produces exactly one
// result beat. A beat is captured in the input register at the edge that accepts it. At the
// first edge after that at which the output register is free or draining, it is decoded and
// applied to the controller state, and its result is loaded into the output register. The
// path is two register stages, input register and output register, from input pins to result
// pins. One beat per cycle is sustained while the result sink stays ready, because the state
// update is a single pass through the decoder and the 8-bit priority resolver. The input
// stays ready while a result waits, until both the input register and the output register are full.
module programmable_interrupt_controller
    import pic_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    pic_item_if.sink        item,
    pic_result_if.source    result
);

    logic        in_vld_reg;
    pic_item_t   item_reg;
    logic        out_vld_reg;
    pic_result_t res_reg;

    logic        advance;
    logic        take_in;
    pic_result_t core_res;

    // Move the held beat into the core when the result slot is free or draining
    assign advance    = in_vld_reg && (!out_vld_reg || result.ready);
    assign take_in    = item.valid && item.ready;
    assign item.ready = !in_vld_reg || advance;

    pic_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .res   (core_res)
    );

    // Track occupancy of both registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.cmd         <= pic_cmd_t'(item.cmd);
            item_reg.port_select <= item.port_select;
            item_reg.write_data  <= item.write_data;
            item_reg.irq_lines   <= item.irq_lines;
        end
        if (advance)
        begin
            res_reg <= core_res;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.read_data    = res_reg.read_data;
    assign result.int_out      = res_reg.int_out;
    assign result.vector       = res_reg.vector;
    assign result.vector_valid = res_reg.vector_valid;

endmodule

`default_nettype wire
